// ===== rtl/gcd_pkg.sv =====
// gcd_pkg: shared constants, cordic angle table and fixed-point constants
// for the great-circle distance pipeline
// no dependencies; evaluated at elaboration only
package gcd_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int FRAC_BITS     = 30;
    localparam int ANG_W         = 34;
    localparam int ROT_LANES     = 4;
    localparam int ROOT_LANES    = 2;
    localparam int RAD_W         = 60;
    localparam int ROOT_W        = RAD_W / 2;
    localparam int LAT_W         = 31;
    localparam int LON_W         = 32;
    localparam int RADIUS_W      = 26;
    localparam int SCALE_W       = 36;
    localparam int OUT_W         = 35;

    localparam logic [SCALE_W-1:0] SCALE_AT_RESET = 36'd6371000000;
    localparam logic [OUT_W-1:0]   OUT_MAX        = '1;

    typedef logic [CORDIC_STAGES-1:0][ANG_W-1:0] atan_tab_t;

    // restoring shift-subtract quotient
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int n = 63; n >= 0; n--) begin
            rem = {rem[63:0], num[n]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[n] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(1/m) in Q62 by its power series
    function automatic logic [63:0] atan_recip(input logic [63:0] m);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] k;
        logic [63:0] t;
        logic        neg;
        logic        done;
        p    = udiv64(64'h4000_0000_0000_0000, m);
        sum  = '0;
        k    = 64'd1;
        neg  = 1'b0;
        done = 1'b0;
        for (int n = 0; n < 48; n++) begin
            if (!done && p != 0) begin
                t   = udiv64(p, k);
                sum = neg ? sum - t : sum + t;
                neg = !neg;
                k   = k + 64'd2;
                if (m >= 64'h8000_0000) begin
                    done = 1'b1;
                end else begin
                    p = udiv64(p, m * m);
                end
            end
        end
        return sum;
    endfunction

    localparam logic [63:0] QUARTER_Q62 = (atan_recip(64'd5) << 2) - atan_recip(64'd239);

    function automatic atan_tab_t build_atan();
        atan_tab_t   tab;
        logic [63:0] t62;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            t62 = (i == 0) ? QUARTER_Q62 : atan_recip(64'd1 << i);
            tab[i] = ANG_W'((t62 + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
        end
        return tab;
    endfunction

    function automatic logic [63:0] build_gain2();
        logic [63:0] g;
        g = 64'd1 << FRAC_BITS;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (2 * i < 64) begin
                g = g + (g >> (2 * i));
            end
        end
        return g;
    endfunction

    function automatic logic [63:0] build_k92();
        logic [63:0] q1;
        logic [63:0] r;
        q1 = udiv64(QUARTER_Q62, 64'd450000000);
        r  = QUARTER_Q62 - q1 * 64'd450000000;
        return (q1 << 30) + udiv64(r << 30, 64'd450000000);
    endfunction

    localparam atan_tab_t   ATAN_TAB = build_atan();
    localparam logic [63:0] GAIN2_64 = build_gain2();
    localparam logic [31:0] GAIN2    = GAIN2_64[31:0];
    localparam logic [63:0] GAIN4_64 = (GAIN2_64 * GAIN2_64 + (64'd1 << (FRAC_BITS - 1)))
                                       >> FRAC_BITS;
    localparam logic [33:0] GAIN4    = GAIN4_64[33:0];
    localparam logic [63:0] K92_64   = build_k92();
    localparam logic [62:0] K92      = K92_64[62:0];

endpackage

// ===== rtl/great_circle_distance.sv =====
// Haversine great-circle distance, fully pipelined: one point pair enters per
// cycle while the output is not stalled (6 angle stages, 24 sine/cosine
// cordic stages, 7 haversine stages, 30 square-root stages, 24 atan2 cordic
// stages, 4 scaling stages). When the result word is not taken the whole
// pipeline holds.
// The radius register may only be written while no pair is in flight.
// great_circle_distance: top level; depends on gcd_pkg, gcd_cordic_rot,
// gcd_isqrt and gcd_cordic_vec
module great_circle_distance
    import gcd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [LAT_W-1:0] s_first_latitude,
    input  logic signed [LON_W-1:0] s_first_longitude,
    input  logic signed [LAT_W-1:0] s_second_latitude,
    input  logic signed [LON_W-1:0] s_second_longitude,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [OUT_W-1:0]       m_distance_mm,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [RADIUS_W-1:0]    cfg_sphere_radius_m
);

    localparam logic signed [LAT_W-1:0] LAT_LIM   = 31'sd900000000;
    localparam logic signed [32:0]      HALF_TURN = 33'sd1800000000;
    localparam logic signed [32:0]      FULL_TURN = 33'sd3600000000;
    localparam logic [93:0] RND_HALF = 94'd1 << 62;
    localparam logic [93:0] RND_LAT  = 94'd1 << 61;
    localparam logic [68:0] RND_F    = 69'd1 << (FRAC_BITS - 1);

    logic en;
    logic [SCALE_W-1:0] scale_reg;

    // front end
    logic                    f1_vld_reg, f2_vld_reg, f3_vld_reg, f4_vld_reg, f5_vld_reg;
    logic                    f6_vld_reg;
    logic signed [LAT_W-1:0] lat1_reg, lat2_reg, lat1_next, lat2_next;
    logic signed [32:0]      dlon_raw_reg;
    logic signed [31:0]      op_reg [ROT_LANES];
    logic signed [31:0]      op_next [ROT_LANES];
    logic [30:0]             mag_reg [ROT_LANES];
    logic [ROT_LANES-1:0]    neg_reg, neg2_reg, neg3_reg;
    logic [62:0]             pl_reg [ROT_LANES];
    logic [61:0]             ph_reg [ROT_LANES];
    logic [31:0]             amag_reg [ROT_LANES];
    logic [31:0]             amag_next [ROT_LANES];
    logic signed [ANG_W-1:0] ang_reg [ROT_LANES];

    // haversine
    logic                    rot_vld;
    logic signed [ANG_W-1:0] rot_x [ROT_LANES];
    logic signed [ANG_W-1:0] rot_y [ROT_LANES];
    logic                    h1_vld_reg, h2_vld_reg, h3_vld_reg, h4_vld_reg, h5_vld_reg;
    logic                    h6_vld_reg, h7_vld_reg;
    logic [30:0]             ms1_reg, ms2_reg, mc1_reg, mc2_reg;
    logic                    cneg1_reg, cneg2_reg, cneg3_reg, cneg4_reg, cneg5_reg;
    logic [61:0]             sq1_reg, sq2_reg, cc_reg;
    logic [31:0]             p1_reg, s2q_reg, c12_reg;
    logic [64:0]             pg_reg, qm_reg;
    logic [34:0]             p1s_reg, qv_reg;
    logic signed [35:0]      a_reg;
    logic [RAD_W-1:0]        rad_reg [ROOT_LANES];
    logic [RAD_W-1:0]        rad_next [ROOT_LANES];

    // tail
    logic                    sq_vld;
    logic [ROOT_W-1:0]       root [ROOT_LANES];
    logic                    vec_vld;
    logic signed [ANG_W-1:0] vec_z;
    logic                    o1_vld_reg, o2_vld_reg, o3_vld_reg, o4_vld_reg;
    logic [32:0]             c_reg;
    logic [64:0]             dl_reg;
    logic [36:0]             dh_reg;
    logic [38:0]             d_reg;
    logic [OUT_W-1:0]        dist_reg;

    assign en        = !o4_vld_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    // radius register, held as radius times 1000
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_AT_RESET;
        end else if (cfg_valid) begin
            scale_reg <= (SCALE_W'(cfg_sphere_radius_m) << 10)
                       - (SCALE_W'(cfg_sphere_radius_m) << 4)
                       - (SCALE_W'(cfg_sphere_radius_m) << 3);
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            f3_vld_reg <= 1'b0;
            f4_vld_reg <= 1'b0;
            f5_vld_reg <= 1'b0;
            f6_vld_reg <= 1'b0;
            h1_vld_reg <= 1'b0;
            h2_vld_reg <= 1'b0;
            h3_vld_reg <= 1'b0;
            h4_vld_reg <= 1'b0;
            h5_vld_reg <= 1'b0;
            h6_vld_reg <= 1'b0;
            h7_vld_reg <= 1'b0;
            o1_vld_reg <= 1'b0;
            o2_vld_reg <= 1'b0;
            o3_vld_reg <= 1'b0;
            o4_vld_reg <= 1'b0;
        end else if (en) begin
            f1_vld_reg <= s_valid;
            f2_vld_reg <= f1_vld_reg;
            f3_vld_reg <= f2_vld_reg;
            f4_vld_reg <= f3_vld_reg;
            f5_vld_reg <= f4_vld_reg;
            f6_vld_reg <= f5_vld_reg;
            h1_vld_reg <= rot_vld;
            h2_vld_reg <= h1_vld_reg;
            h3_vld_reg <= h2_vld_reg;
            h4_vld_reg <= h3_vld_reg;
            h5_vld_reg <= h4_vld_reg;
            h6_vld_reg <= h5_vld_reg;
            h7_vld_reg <= h6_vld_reg;
            o1_vld_reg <= vec_vld;
            o2_vld_reg <= o1_vld_reg;
            o3_vld_reg <= o2_vld_reg;
            o4_vld_reg <= o3_vld_reg;
        end
    end

    // latitude clamp
    always_comb begin
        if (s_first_latitude > LAT_LIM) begin
            lat1_next = LAT_LIM;
        end else if (s_first_latitude < -LAT_LIM) begin
            lat1_next = -LAT_LIM;
        end else begin
            lat1_next = s_first_latitude;
        end
        if (s_second_latitude > LAT_LIM) begin
            lat2_next = LAT_LIM;
        end else if (s_second_latitude < -LAT_LIM) begin
            lat2_next = -LAT_LIM;
        end else begin
            lat2_next = s_second_latitude;
        end
    end

    // differences, longitude wrap into half-open turn
    always_comb begin
        logic signed [32:0] w;
        if (dlon_raw_reg >= HALF_TURN) begin
            w = dlon_raw_reg - FULL_TURN;
        end else if (dlon_raw_reg < -HALF_TURN) begin
            w = dlon_raw_reg + FULL_TURN;
        end else begin
            w = dlon_raw_reg;
        end
        op_next[0] = {lat2_reg[LAT_W-1], lat2_reg} - {lat1_reg[LAT_W-1], lat1_reg};
        op_next[1] = w[31:0];
        op_next[2] = {lat1_reg[LAT_W-1], lat1_reg};
        op_next[3] = {lat2_reg[LAT_W-1], lat2_reg};
    end

    // radian scaling, half angles for the deltas
    always_comb begin
        logic [93:0] sum;
        for (int i = 0; i < ROT_LANES; i++) begin
            sum = {ph_reg[i], 32'b0} + 94'(pl_reg[i]);
            if (i < 2) begin
                amag_next[i] = 32'((sum + RND_HALF) >> 63);
            end else begin
                amag_next[i] = 32'((sum + RND_LAT) >> 62);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lat1_reg     <= lat1_next;
            lat2_reg     <= lat2_next;
            dlon_raw_reg <= {s_second_longitude[LON_W-1], s_second_longitude}
                          - {s_first_longitude[LON_W-1], s_first_longitude};
            op_reg       <= op_next;
            neg2_reg     <= neg_reg;
            neg3_reg     <= neg2_reg;
            amag_reg     <= amag_next;
            for (int i = 0; i < ROT_LANES; i++) begin
                neg_reg[i] <= op_reg[i][31];
                mag_reg[i] <= op_reg[i][31] ? 31'(-op_reg[i]) : op_reg[i][30:0];
                pl_reg[i]  <= 63'(mag_reg[i]) * 63'(K92[31:0]);
                ph_reg[i]  <= 62'(mag_reg[i]) * 62'(K92[62:32]);
                ang_reg[i] <= neg3_reg[i] ? -ANG_W'(amag_reg[i]) : ANG_W'(amag_reg[i]);
            end
        end
    end

    gcd_cordic_rot u_rot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f6_vld_reg),
        .angle     (ang_reg),
        .out_valid (rot_vld),
        .cos_x     (rot_x),
        .sin_y     (rot_y)
    );

    // a = sin^2(dlat/2) g2 + cos cos sin^2(dlon/2), all scaled by gain
    always_comb begin
        logic [33:0] ac;
        if (a_reg[35]) begin
            ac = '0;
        end else if (a_reg > $signed({2'b0, GAIN4})) begin
            ac = GAIN4;
        end else begin
            ac = a_reg[33:0];
        end
        rad_next[0] = RAD_W'(ac) << (57 - FRAC_BITS);
        rad_next[1] = RAD_W'(GAIN4 - ac) << (57 - FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ms1_reg   <= 31'(rot_y[0][ANG_W-1] ? -rot_y[0] : rot_y[0]);
            ms2_reg   <= 31'(rot_y[1][ANG_W-1] ? -rot_y[1] : rot_y[1]);
            mc1_reg   <= 31'(rot_x[2][ANG_W-1] ? -rot_x[2] : rot_x[2]);
            mc2_reg   <= 31'(rot_x[3][ANG_W-1] ? -rot_x[3] : rot_x[3]);
            cneg1_reg <= rot_x[2][ANG_W-1] ^ rot_x[3][ANG_W-1];
            sq1_reg   <= 62'(ms1_reg) * 62'(ms1_reg);
            sq2_reg   <= 62'(ms2_reg) * 62'(ms2_reg);
            cc_reg    <= 62'(mc1_reg) * 62'(mc2_reg);
            cneg2_reg <= cneg1_reg;
            p1_reg    <= 32'((sq1_reg + 62'(RND_F)) >> FRAC_BITS);
            s2q_reg   <= 32'((sq2_reg + 62'(RND_F)) >> FRAC_BITS);
            c12_reg   <= 32'((cc_reg + 62'(RND_F)) >> FRAC_BITS);
            cneg3_reg <= cneg2_reg && (cc_reg + 62'(RND_F)) >= (62'd1 << FRAC_BITS);
            pg_reg    <= 65'(p1_reg) * 65'(GAIN2);
            qm_reg    <= 65'(c12_reg) * 65'(s2q_reg);
            cneg4_reg <= cneg3_reg;
            p1s_reg   <= 35'((pg_reg + 65'(RND_F)) >> FRAC_BITS);
            qv_reg    <= 35'((qm_reg + 65'(RND_F)) >> FRAC_BITS);
            cneg5_reg <= cneg4_reg;
            a_reg     <= cneg5_reg ? $signed(36'(p1s_reg)) - $signed(36'(qv_reg))
                                   : $signed(36'(p1s_reg)) + $signed(36'(qv_reg));
            rad_reg   <= rad_next;
        end
    end

    gcd_isqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (h7_vld_reg),
        .radicand  (rad_reg),
        .out_valid (sq_vld),
        .root      (root)
    );

    gcd_cordic_vec u_vec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_vld),
        .x_in      ($signed(ANG_W'(root[1]))),
        .y_in      ($signed(ANG_W'(root[0]))),
        .out_valid (vec_vld),
        .angle     (vec_z)
    );

    // central angle times radius, saturated
    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg    <= vec_z[ANG_W-1] ? '0 : {vec_z[31:0], 1'b0};
            dl_reg   <= 65'(c_reg) * 65'(scale_reg[31:0]);
            dh_reg   <= 37'(c_reg) * 37'(scale_reg[SCALE_W-1:32]);
            d_reg    <= 39'(({32'(0), dh_reg} << 32) + {4'b0, dl_reg} + RND_F >> FRAC_BITS);
            dist_reg <= (d_reg > 39'(OUT_MAX)) ? OUT_MAX : d_reg[OUT_W-1:0];
        end
    end

    assign m_valid       = o4_vld_reg;
    assign m_distance_mm = dist_reg;

endmodule

// ===== rtl/gcd_cordic_rot.sv =====
// gcd_cordic_rot: rotation-mode cordic, one register stage per iteration,
// four lanes side by side
// depends on gcd_pkg
module gcd_cordic_rot
    import gcd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [ANG_W-1:0] angle [ROT_LANES],
    output logic                    out_valid,
    output logic signed [ANG_W-1:0] cos_x [ROT_LANES],
    output logic signed [ANG_W-1:0] sin_y [ROT_LANES]
);

    localparam logic signed [ANG_W-1:0] X0 = ANG_W'(64'd1 << FRAC_BITS);

    logic [CORDIC_STAGES-1:0]  vld_reg;
    logic signed [ANG_W-1:0]   x_reg  [CORDIC_STAGES][ROT_LANES];
    logic signed [ANG_W-1:0]   y_reg  [CORDIC_STAGES][ROT_LANES];
    logic signed [ANG_W-1:0]   z_reg  [CORDIC_STAGES][ROT_LANES];
    logic signed [ANG_W-1:0]   x_next [CORDIC_STAGES][ROT_LANES];
    logic signed [ANG_W-1:0]   y_next [CORDIC_STAGES][ROT_LANES];
    logic signed [ANG_W-1:0]   z_next [CORDIC_STAGES][ROT_LANES];

    always_comb begin
        logic signed [ANG_W-1:0] xs;
        logic signed [ANG_W-1:0] ys;
        logic signed [ANG_W-1:0] zs;
        logic signed [ANG_W-1:0] t;
        int p;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            p = (i == 0) ? 0 : i - 1;
            t = ATAN_TAB[i];
            for (int l = 0; l < ROT_LANES; l++) begin
                if (i == 0) begin
                    xs = X0;
                    ys = '0;
                    zs = angle[l];
                end else begin
                    xs = x_reg[p][l];
                    ys = y_reg[p][l];
                    zs = z_reg[p][l];
                end
                if (!zs[ANG_W-1]) begin
                    x_next[i][l] = xs - (ys >>> i);
                    y_next[i][l] = ys + (xs >>> i);
                    z_next[i][l] = zs - t;
                end else begin
                    x_next[i][l] = xs + (ys >>> i);
                    y_next[i][l] = ys - (xs >>> i);
                    z_next[i][l] = zs + t;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[CORDIC_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign out_valid = vld_reg[CORDIC_STAGES-1];
    assign cos_x     = x_reg[CORDIC_STAGES-1];
    assign sin_y     = y_reg[CORDIC_STAGES-1];

endmodule

// ===== rtl/gcd_isqrt.sv =====
// gcd_isqrt: floor square root, one result bit per register stage,
// two lanes side by side
// depends on gcd_pkg
module gcd_isqrt
    import gcd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  radicand [ROOT_LANES],
    output logic              out_valid,
    output logic [ROOT_W-1:0] root [ROOT_LANES]
);

    logic [ROOT_W-1:0] vld_reg;
    logic [RAD_W-1:0]  v_reg  [ROOT_W][ROOT_LANES];
    logic [RAD_W-1:0]  r_reg  [ROOT_W][ROOT_LANES];
    logic [RAD_W-1:0]  v_next [ROOT_W][ROOT_LANES];
    logic [RAD_W-1:0]  r_next [ROOT_W][ROOT_LANES];

    always_comb begin
        logic [RAD_W-1:0] vs;
        logic [RAD_W-1:0] rs;
        logic [RAD_W-1:0] bit_w;
        logic [RAD_W:0]   trial;
        int p;
        for (int j = 0; j < ROOT_W; j++) begin
            p     = (j == 0) ? 0 : j - 1;
            bit_w = RAD_W'(1) << (RAD_W - 2 - 2 * j);
            for (int l = 0; l < ROOT_LANES; l++) begin
                if (j == 0) begin
                    vs = radicand[l];
                    rs = '0;
                end else begin
                    vs = v_reg[p][l];
                    rs = r_reg[p][l];
                end
                trial = {1'b0, rs} + {1'b0, bit_w};
                if ({1'b0, vs} >= trial) begin
                    v_next[j][l] = vs - trial[RAD_W-1:0];
                    r_next[j][l] = (rs >> 1) + bit_w;
                end else begin
                    v_next[j][l] = vs;
                    r_next[j][l] = rs >> 1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[ROOT_W-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg <= v_next;
            r_reg <= r_next;
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];

    always_comb begin
        for (int l = 0; l < ROOT_LANES; l++) begin
            root[l] = r_reg[ROOT_W-1][l][ROOT_W-1:0];
        end
    end

endmodule

// ===== rtl/gcd_cordic_vec.sv =====
// gcd_cordic_vec: vectoring-mode cordic giving atan2, one register stage
// per iteration
// depends on gcd_pkg
module gcd_cordic_vec
    import gcd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [ANG_W-1:0] x_in,
    input  logic signed [ANG_W-1:0] y_in,
    output logic                    out_valid,
    output logic signed [ANG_W-1:0] angle
);

    logic [CORDIC_STAGES-1:0] vld_reg;
    logic signed [ANG_W-1:0]  x_reg  [CORDIC_STAGES];
    logic signed [ANG_W-1:0]  y_reg  [CORDIC_STAGES];
    logic signed [ANG_W-1:0]  z_reg  [CORDIC_STAGES];
    logic signed [ANG_W-1:0]  x_next [CORDIC_STAGES];
    logic signed [ANG_W-1:0]  y_next [CORDIC_STAGES];
    logic signed [ANG_W-1:0]  z_next [CORDIC_STAGES];

    always_comb begin
        logic signed [ANG_W-1:0] xs;
        logic signed [ANG_W-1:0] ys;
        logic signed [ANG_W-1:0] zs;
        logic signed [ANG_W-1:0] t;
        int p;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            p = (i == 0) ? 0 : i - 1;
            t = ATAN_TAB[i];
            if (i == 0) begin
                xs = x_in;
                ys = y_in;
                zs = '0;
            end else begin
                xs = x_reg[p];
                ys = y_reg[p];
                zs = z_reg[p];
            end
            if (!ys[ANG_W-1]) begin
                x_next[i] = xs + (ys >>> i);
                y_next[i] = ys - (xs >>> i);
                z_next[i] = zs + t;
            end else begin
                x_next[i] = xs - (ys >>> i);
                y_next[i] = ys + (xs >>> i);
                z_next[i] = zs - t;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[CORDIC_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign out_valid = vld_reg[CORDIC_STAGES-1];
    assign angle     = z_reg[CORDIC_STAGES-1];

endmodule
